[src/arpresp_pkg.sv]
// arpresp_pkg: shared types, constants and the reply frame byte function
// for the arp request responder; no dependencies
package arpresp_pkg;

  localparam int unsigned PAYLOAD_LEN = 28;
  localparam int unsigned FRAME_LEN   = 6 + 6 + 2 + 28;

  localparam int unsigned CNT_W = 5;
  localparam int unsigned IDX_W = 6;

  typedef enum logic {
    REG_OWN_MAC = 1'b0,
    REG_OWN_IP  = 1'b1
  } cfg_reg_t;

  // everything one reply frame needs, frozen at the end of the request
  typedef struct packed {
    logic [47:0] req_mac;
    logic [31:0] req_ip;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
  } reply_desc_t;

  typedef struct packed {
    logic        vld;
    reply_desc_t desc;
  } reply_push_t;

  localparam logic [7:0] ARP_HEAD [8] = '{
    8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };

  localparam logic [7:0] REPLY_HEAD [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    logic [47:0] s;
    s = mac << {i, 3'b000};
    return s[47:40];
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
    logic [31:0] s;
    s = ip << {i, 3'b000};
    return s[31:24];
  endfunction

  function automatic logic [7:0] frame_at(input reply_desc_t d, input logic [IDX_W-1:0] k);
    logic [IDX_W-1:0] off;
    logic [7:0]       res;
    off = '0;
    if (k < 6'd6) begin
      res = mac_byte(d.req_mac, k[2:0]);
    end else if (k < 6'd12) begin
      off = k - 6'd6;
      res = mac_byte(d.own_mac, off[2:0]);
    end else if (k < 6'd22) begin
      off = k - 6'd12;
      res = REPLY_HEAD[off[3:0]];
    end else if (k < 6'd28) begin
      off = k - 6'd22;
      res = mac_byte(d.own_mac, off[2:0]);
    end else if (k < 6'd32) begin
      res = ip_byte(d.own_ip, k[1:0]);
    end else if (k < 6'd38) begin
      off = k - 6'd32;
      res = mac_byte(d.req_mac, off[2:0]);
    end else begin
      off = k - 6'd38;
      res = ip_byte(d.req_ip, off[1:0]);
    end
    return res;
  endfunction

endpackage

[src/arpresp_front.sv]
// arpresp_front: parses and checks the incoming arp payload, captures the
// sender addresses and hands a reply descriptor on; uses arpresp_pkg
module arpresp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [7:0]                payload_byte,
  input  logic                      last,
  input  logic [47:0]               own_mac,
  input  logic [31:0]               own_ip,
  output arpresp_pkg::reply_push_t  push
);
  import arpresp_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ok_r, ok_nxt;
  logic [47:0]      mac_r, mac_nxt;
  logic [31:0]      ip_r, ip_nxt;
  logic [CNT_W-1:0] ip_off;

  assign ip_off = cnt_r - CNT_W'(24);

  always_comb begin
    cnt_nxt = cnt_r;
    ok_nxt  = ok_r;
    mac_nxt = mac_r;
    ip_nxt  = ip_r;
    if (cnt_r < CNT_W'(PAYLOAD_LEN)) begin
      if (cnt_r < CNT_W'(8)) begin
        if (payload_byte != ARP_HEAD[cnt_r[2:0]]) ok_nxt = 1'b0;
      end else if (cnt_r < CNT_W'(14)) begin
        mac_nxt = {mac_r[39:0], payload_byte};
      end else if (cnt_r < CNT_W'(18)) begin
        ip_nxt = {ip_r[23:0], payload_byte};
      end else if (cnt_r >= CNT_W'(24)) begin
        if (payload_byte != ip_byte(own_ip, ip_off[1:0])) ok_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    push.vld          = accept && last && (cnt_nxt == CNT_W'(PAYLOAD_LEN)) && ok_nxt;
    push.desc.req_mac = mac_nxt;
    push.desc.req_ip  = ip_nxt;
    push.desc.own_mac = own_mac;
    push.desc.own_ip  = own_ip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ok_r  <= 1'b1;
    end else if (accept) begin
      // a last byte always starts the next payload fresh
      cnt_r <= last ? '0 : cnt_nxt;
      ok_r  <= last ? 1'b1 : ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mac_r <= mac_nxt;
      ip_r  <= ip_nxt;
    end
  end

endmodule

[src/arpresp_fifo.sv]
// arpresp_fifo: two-entry queue of reply descriptors between front and back
// uses arpresp_pkg
module arpresp_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  arpresp_pkg::reply_push_t  push,
  input  logic                      pop,
  output arpresp_pkg::reply_desc_t  head,
  output logic                      full,
  output logic                      empty
);
  import arpresp_pkg::*;

  reply_desc_t mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.vld) mem_r[wr_ptr_r] <= push.desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push.vld) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({push.vld, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/arpresp_back.sv]
// arpresp_back: takes reply descriptors from the queue and streams the
// 42-byte reply frame through an output register; uses arpresp_pkg
module arpresp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  arpresp_pkg::reply_desc_t  head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,
  output logic                      out_tlast
);
  import arpresp_pkg::*;

  reply_desc_t      desc_r;
  logic             busy_r;
  logic [IDX_W-1:0] idx_r;
  logic             vld_r;
  logic [7:0]       data_r;
  logic             last_r;
  logic             adv;
  logic             end_byte;

  assign adv      = !vld_r || out_tready;
  assign pop      = !busy_r && !empty;
  assign end_byte = (idx_r == IDX_W'(FRAME_LEN - 1));

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r && adv) begin
        idx_r <= idx_r + IDX_W'(1);
        if (end_byte) busy_r <= 1'b0;
      end
      if (adv) vld_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) desc_r <= head;
    if (adv) begin
      data_r <= frame_at(desc_r, idx_r);
      last_r <= busy_r && end_byte;
    end
  end

endmodule

[src/arp_request_responder.sv]
// arp_request_responder: top level, checks arp requests for this station
// and streams ethernet arp replies; uses arpresp_pkg, front, fifo and back
//
// Payload bytes are taken one per cycle with no gaps needed; each byte is
// checked as it arrives and a request for own_ip that ends on its 28th or a
// later byte queues one reply. A reply leaves as 42 bytes, one per cycle the
// sink takes them, with out_tlast on the 42nd. Between back-to-back replies the
// output goes idle while the next one is loaded from the queue; that load is
// hidden when the sink holds off the last byte of the previous reply. The
// queue holds two pending replies; in_tready drops only while it is full.
// own_mac and own_ip are sampled when the last request byte is taken.
module arp_request_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata
);
  import arpresp_pkg::*;

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic        accept;
  reply_push_t push;
  reply_desc_t head;
  logic        full, empty, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OWN_MAC: own_mac_r <= cfg_wdata;
        REG_OWN_IP:  own_ip_r  <= cfg_wdata[31:0];
        default:     own_ip_r  <= own_ip_r;
      endcase
    end
  end

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  arpresp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .payload_byte (in_tdata),
    .last         (in_tlast),
    .own_mac      (own_mac_r),
    .own_ip       (own_ip_r),
    .push         (push)
  );

  arpresp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  arpresp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.vld && full))
    else $error("reply queued while queue full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("reply taken from empty queue");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("waiting output item changed");

endmodule

[tb/arp_request_responder_tb.sv]
// arp_request_responder_tb: self-checking bench for the arp request responder
// directed request table plus random requests, replies checked against a local
// predictor of the reply frame; uses arpresp_pkg for the register index type
`timescale 1ns / 1ps

module arp_request_responder_tb;
  import arpresp_pkg::*;

  localparam int PL_MAX      = 64;
  localparam int RAND_ITEMS  = 10;
  localparam int DRAIN       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int ROWS        = 5;

  // request header as it must appear on the wire, and the fixed part of a reply
  localparam logic [63:0] REQ_HEAD   = 64'h0001_0800_0604_0001;
  localparam logic [79:0] REPLY_HEAD = 80'h0806_0001_0800_0604_0002;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_item_t;

  typedef struct packed {
    logic        set_cfg;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [47:0] snd_mac;
    logic [31:0] snd_ip;
    logic [5:0]  len;
    logic [4:0]  bad_pos;
    logic [7:0]  bad_xor;
    logic [5:0]  reply_n;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] payload_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] frame_byte
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_OWN_MAC;
  logic [47:0] cfg_wdata = '0;

  // predictor state
  int          rq_count = 0;
  logic        rq_ok = 1'b1;
  logic [47:0] rq_mac = '0;
  logic [31:0] rq_ip = '0;
  logic [47:0] my_mac = '0;
  logic [31:0] my_ip = '0;

  frame_item_t expected_frame_q[$];
  int          frame_bytes_taken = 0;
  int          mismatch_cnt = 0;
  int          stall_cycles = 0;

  logic [7:0]  pl [PL_MAX];
  logic [31:0] own_ip_now = '0;

  dir_row_t dir_rows [ROWS] = '{
    // extreme registers, sender all zeros
    '{1'b1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'h0, 32'h0, 6'd28, 5'd0, 8'h00, 6'd42},
    // sender all ones, long payload, count must saturate past the 5-bit range
    '{1'b0, 48'h0, 32'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd34, 5'd0, 8'h00, 6'd42},
    // short payload, one byte too few
    '{1'b0, 48'h0, 32'h0, 48'h0200_5E10_2233, 32'hC0A8_0001, 6'd27, 5'd0, 8'h00, 6'd0},
    // broken opcode
    '{1'b0, 48'h0, 32'h0, 48'h0200_5E10_2233, 32'hC0A8_0001, 6'd28, 5'd7, 8'h03, 6'd0},
    // target ip not ours in its last byte
    '{1'b0, 48'h0, 32'h0, 48'h0200_5E10_2233, 32'hC0A8_0001, 6'd28, 5'd27, 8'h01, 6'd0}
  };

  arp_request_responder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // advance the request tracker by one payload byte, queue the reply it causes
  task automatic track_payload_byte(input logic [7:0] b, input logic l);
    logic [335:0] frame;
    if (rq_count < 28) begin
      if (rq_count < 8) begin
        if (b != REQ_HEAD[63 - 8 * rq_count -: 8]) rq_ok = 1'b0;
      end else if (rq_count < 14) begin
        rq_mac = {rq_mac[39:0], b};
      end else if (rq_count < 18) begin
        rq_ip = {rq_ip[23:0], b};
      end else if (rq_count >= 24) begin
        if (b != my_ip[31 - 8 * (rq_count - 24) -: 8]) rq_ok = 1'b0;
      end
      rq_count++;
    end
    if (l) begin
      if (rq_count == 28 && rq_ok) begin
        frame = {rq_mac, my_mac, REPLY_HEAD, my_mac, my_ip, rq_mac, rq_ip};
        for (int k = 0; k < 42; k++) begin
          expected_frame_q.push_back('{frame[335 - 8 * k -: 8], k == 41});
        end
      end
      rq_count = 0;
      rq_ok = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    frame_item_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OWN_MAC: my_mac = cfg_wdata;
          REG_OWN_IP:  my_ip  = cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        frame_bytes_taken++;
        if (expected_frame_q.size() == 0) begin
          note_mismatch($sformatf("unexpected frame byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          want = expected_frame_q.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.last)
            note_mismatch($sformatf("frame byte expected %02h last %0b, got %02h last %0b",
                                    want.data, want.last, out_tdata, out_tlast));
        end
      end
      if (in_tvalid && in_tready) track_payload_byte(in_tdata, in_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // sink: stretches of steady ready mixed with random stalls
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l, input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_payload(input int len, input bit steady);
    for (int p = 0; p < len; p++) send_byte(pl[p], p == len - 1, steady);
  endtask

  // well-formed request in pl[0..27], random filler after it
  task automatic fill_request(input logic [47:0] snd_mac, input logic [31:0] snd_ip,
                              input logic [31:0] tgt_ip);
    logic [223:0] body;
    logic [63:0]  r64;
    r64  = {$urandom, $urandom};
    body = {REQ_HEAD, snd_mac, snd_ip, r64[47:0], tgt_ip};
    for (int p = 0; p < PL_MAX; p++)
      pl[p] = (p < 28) ? body[223 - 8 * p -: 8] : 8'($urandom_range(0, 255));
  endtask

  // hold the sender until every expected byte is out and the block has settled
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_regs(input logic [47:0] mac, input logic [31:0] ip);
    logic [15:0] junk;
    junk = $urandom_range(0, 65535);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    cfg_index <= REG_OWN_IP;
    cfg_wdata <= {junk, ip};
    @(posedge clk);
    cfg_we <= 1'b0;
    own_ip_now = ip;
  endtask

  function automatic logic [63:0] pick_word();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin
    dir_row_t    row;
    int          seen0;
    int          rand_items;
    int          pay_no;
    int          kind;
    int          len;
    int          pos;
    bit          steady;
    logic [63:0] w_mac;
    logic [63:0] w_ip;
    logic [63:0] s_mac;
    logic [63:0] s_ip;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      row = dir_rows[r];
      if (row.set_cfg) write_regs(row.mac, row.ip);
      fill_request(row.snd_mac, row.snd_ip, own_ip_now);
      pl[row.bad_pos] = pl[row.bad_pos] ^ row.bad_xor;
      seen0 = frame_bytes_taken;
      send_payload(row.len, 1'b0);
      wait_idle();
      if (frame_bytes_taken - seen0 != row.reply_n)
        note_mismatch($sformatf("table row %0d: expected %0d reply bytes, got %0d",
                                r, row.reply_n, frame_bytes_taken - seen0));
    end

    // random part: mostly good requests with random content, some broken or noise
    rand_items = 0;
    pay_no = 0;
    while (rand_items < RAND_ITEMS) begin
      if (pay_no % 2 == 0) begin
        wait_idle();
        w_mac = pick_word();
        w_ip  = pick_word();
        write_regs(w_mac[47:0], w_ip[31:0]);
      end
      s_mac = pick_word();
      s_ip  = pick_word();
      fill_request(s_mac[47:0], s_ip[31:0], own_ip_now);
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(29, 40) : 28;
      kind = $urandom_range(0, 9);
      case (kind)
        6, 7: begin
          pos = $urandom_range(0, 11);
          if (pos >= 8) pos = pos + 16;
          pl[pos] = pl[pos] ^ 8'($urandom_range(1, 255));
        end
        8: len = $urandom_range(1, 27);
        9: begin
          for (int p = 0; p < PL_MAX; p++) pl[p] = 8'($urandom_range(0, 255));
          len = $urandom_range(1, 40);
        end
        default: ;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      send_payload(len, steady);
      rand_items += len;
      pay_no++;
    end

    wait_idle();
    if (mismatch_cnt == 0 && expected_frame_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
